FILE: rtl/spr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg - spectrum packet reassembly shared definitions
// Field widths, fixed packet geometry, payload and state types.
// ----------------------------------------------------------------------------
package spr_pkg;

    // fixed geometry: sub-packet index is the low bits of the sequence number
    localparam int SUB_W                = 2;
    localparam int PACKETS_PER_SPECTRUM = 1 << SUB_W;

    // defaults for the top level parameters
    localparam int CHANNELS_DEF   = 2048;
    localparam int MAX_REPEAT_DEF = 255;

    // field widths
    localparam int SEQ_W      = 64;
    localparam int SPEC_W     = SEQ_W - SUB_W;
    localparam int POWER_W    = 32;
    localparam int ADDR_OUT_W = 11;
    localparam int REP_W      = 8;

    // one channel word on the input channel
    typedef struct packed {
        logic [SEQ_W-1:0]          sequence_number;
        logic                      first_of_packet;
        logic signed [POWER_W-1:0] xx_power;
        logic signed [POWER_W-1:0] yy_power;
    } spr_in_t;

    // one result word for the spectrum buffer
    typedef struct packed {
        logic                      write_valid;
        logic [ADDR_OUT_W-1:0]     channel_address;
        logic signed [POWER_W-1:0] xx_out;
        logic signed [POWER_W-1:0] yy_out;
        logic                      missed_packet;
        logic                      spectrum_done;
        logic [REP_W-1:0]          repeat_count;
    } spr_out_t;

    // packet tracking state carried from word to word
    typedef struct packed {
        logic              waiting;
        logic              seen;
        logic              dropped;
        logic              written;
        logic [SUB_W-1:0]  cur_sub;
        logic [SEQ_W-1:0]  prev_seq;
        logic [SPEC_W-1:0] cur_spec;
        logic [SPEC_W-1:0] last_spec;
    } spr_state_t;

endpackage
`default_nettype wire

FILE: rtl/spr_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_step - per-word reassembly logic
// Updates packet tracking state for one channel word and forms its result.
// ----------------------------------------------------------------------------
module spr_step import spr_pkg::*; #(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_REPEAT = MAX_REPEAT_DEF,
    localparam int WPP   = CHANNELS / PACKETS_PER_SPECTRUM,
    localparam int POS_W = (WPP > 1) ? $clog2(WPP) : 1
) (
    input  wire spr_in_t          in_data,
    input  wire spr_state_t       st,
    input  wire logic [POS_W-1:0] pos,
    input  wire logic             flip_band,
    output spr_state_t            st_next,
    output logic [POS_W-1:0]      pos_next,
    output spr_out_t              res
);

    localparam int ADDR_W = $clog2(CHANNELS);
    localparam int EXT_W  = (ADDR_W > ADDR_OUT_W) ? ADDR_W : ADDR_OUT_W;
    localparam int SAT    = (MAX_REPEAT < 255) ? MAX_REPEAT : 255;

    logic [SUB_W-1:0]  sub;
    logic              missed;
    logic              wv;
    logic              last_word;
    logic              ahead;
    logic [EXT_W-1:0]  addr_lin;
    logic [EXT_W-1:0]  addr_flip;
    logic [SPEC_W-1:0] gap;

    assign sub = in_data.sequence_number[SUB_W-1:0];

    // sequence tracking and word position
    always_comb begin
        st_next  = st;
        pos_next = pos;
        missed   = 1'b0;
        if (in_data.first_of_packet) begin
            pos_next = '0;
            if (st.waiting && (sub != '0)) begin
                st_next.dropped = 1'b1;
            end else begin
                st_next.waiting  = 1'b0;
                st_next.dropped  = 1'b0;
                missed           = st.seen &&
                                   (in_data.sequence_number != st.prev_seq + 64'd1);
                st_next.seen     = 1'b1;
                st_next.prev_seq = in_data.sequence_number;
                st_next.cur_sub  = sub;
                st_next.cur_spec = in_data.sequence_number[SEQ_W-1:SUB_W];
            end
        end else if (pos == POS_W'(WPP - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos + 1'b1;
        end

        // completed spectrum bookkeeping
        if (!st_next.waiting && !st_next.dropped &&
            (st_next.cur_sub == SUB_W'(PACKETS_PER_SPECTRUM - 1)) &&
            (pos_next == POS_W'(WPP - 1))) begin
            st_next.written   = 1'b1;
            st_next.last_spec = st_next.cur_spec;
        end
    end

    // buffer address, optionally mirrored
    assign wv        = !st_next.waiting && !st_next.dropped;
    assign addr_lin  = EXT_W'(st_next.cur_sub) * EXT_W'(WPP) + EXT_W'(pos_next);
    assign addr_flip = flip_band ? (EXT_W'(CHANNELS - 1) - addr_lin) : addr_lin;
    assign last_word = (st_next.cur_sub == SUB_W'(PACKETS_PER_SPECTRUM - 1)) &&
                       (pos_next == POS_W'(WPP - 1));

    // skipped spectra since the last one completed
    assign ahead = st_next.cur_spec > st.last_spec;
    assign gap   = st_next.cur_spec - st.last_spec - SPEC_W'(1);

    // result word
    always_comb begin
        res                 = '0;
        res.write_valid     = wv;
        res.xx_out          = in_data.xx_power;
        res.yy_out          = in_data.yy_power;
        if (wv) begin
            res.channel_address = addr_flip[ADDR_OUT_W-1:0];
            res.missed_packet   = missed;
            if (last_word) begin
                res.spectrum_done = 1'b1;
                if (st.written && ahead) begin
                    res.repeat_count = (gap > SPEC_W'(SAT)) ? REP_W'(SAT)
                                                             : gap[REP_W-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/spectrum_packet_reassembly.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_packet_reassembly - packetised spectrum reassembly
// Places channel words into spectrum buffer addresses and checks sequence.
// ----------------------------------------------------------------------------
// Usage
//   s_valid/s_ready/s_data carry one channel word per transfer: sequence
//   number, first-of-packet mark and the XX and YY powers. m_valid/m_ready/
//   m_data carry one buffer write per word: write_valid, channel address,
//   powers, missed-packet flag, spectrum-done mark and repeat count.
//   cfg_we/cfg_wdata write flip_band; write it while idle.
// Pipeline: an accepted word is held in the input register, and its result is
//   formed from it and held in the result register that drives m_data.
// Throughput: one word per cycle while m_ready is high; the per-word state update is a
//   single pass of logic between the input register and the result register.
// Reset: both channels empty, flip_band cleared, and the block discards
//   packets until one arrives with sub-index 0.
// Stall: while m_ready is low the result holds, one further word waits in
//   the input register, and s_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module spectrum_packet_reassembly import spr_pkg::*; #(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_REPEAT = MAX_REPEAT_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire spr_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output spr_out_t     m_data
);

    localparam int WPP   = CHANNELS / PACKETS_PER_SPECTRUM;
    localparam int POS_W = (WPP > 1) ? $clog2(WPP) : 1;
    localparam int SAT   = (MAX_REPEAT < 255) ? MAX_REPEAT : 255;

    logic             flip_band_reg;
    logic             in_valid_reg,  in_valid_next;
    spr_in_t          in_data_reg;
    logic             out_valid_reg, out_valid_next;
    spr_out_t         out_data_reg,  out_data_next;
    spr_state_t       st_reg,        st_next;
    spr_state_t       st_rst;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic             out_free;
    logic             adv;
    logic             s_xfer;

    // handshake
    assign out_free = !out_valid_reg || m_ready;
    assign adv      = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        in_valid_next  = s_xfer ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
        out_valid_next = adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // reset value of the tracking state: waiting for a spectrum start
    always_comb begin
        st_rst         = '0;
        st_rst.waiting = 1'b1;
    end

    // per-word logic
    spr_step #(
        .CHANNELS   (CHANNELS),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_step (
        .in_data   (in_data_reg),
        .st        (st_reg),
        .pos       (pos_reg),
        .flip_band (flip_band_reg),
        .st_next   (st_next),
        .pos_next  (pos_next),
        .res       (out_data_next)
    );

    // control and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_band_reg     <= 1'b0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            st_reg            <= st_rst;
            pos_reg           <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                flip_band_reg <= cfg_wdata;
            end
            if (adv) begin
                st_reg  <= st_next;
                pos_reg <= pos_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    a_hold_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register changed while result stalled");

    a_done_marks_written : assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && out_data_next.spectrum_done) |=> st_reg.written)
        else $error("completed spectrum not recorded");

    a_write_after_start : assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && out_data_next.write_valid) |=> !st_reg.waiting)
        else $error("stored word while still waiting for start");

    a_repeat_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.repeat_count <= REP_W'(SAT)))
        else $error("repeat count above saturation limit");

endmodule
`default_nettype wire

FILE: tb/spr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spr_checker - buffer write checker for spectrum packet reassembly
// Watches the channel word and buffer write channels, works out each buffer
// write from the accepted words and compares every field in order.
// ----------------------------------------------------------------------------
module spr_checker import spr_pkg::*; #(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_REPEAT = MAX_REPEAT_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    input  logic     s_valid,
    input  logic     s_ready,
    input  spr_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  spr_out_t m_data,
    output int       fail_count,
    output int       pending,
    output int       writes_checked,
    output int       spectra_done,
    output int       gaps_flagged
);

    localparam int WORDS   = CHANNELS / PACKETS_PER_SPECTRUM;
    localparam int REP_MAX = (1 << REP_W) - 1;

    // own copy of the packet tracking state and the band flip
    logic              band_flipped;
    logic              awaiting_start;
    logic              have_packet;
    logic              pkt_dropped;
    logic              spec_written;
    logic [SUB_W-1:0]  cur_sub;
    logic [SEQ_W-1:0]  prev_seq;
    logic [SPEC_W-1:0] cur_spec;
    logic [SPEC_W-1:0] last_spec;
    int                word_pos;

    // buffer writes still owed by the block, oldest first
    spr_out_t writes_due[$];

    // next buffer write for one channel word, advancing the tracking state
    function automatic spr_out_t reassemble_word(input spr_in_t w);
        spr_out_t          r;
        logic [SUB_W-1:0]  sub;
        logic [SPEC_W-1:0] gap;
        int                lin;
        r        = '0;
        r.xx_out = w.xx_power;
        r.yy_out = w.yy_power;

        // header word: start a packet, or keep dropping until sub-index 0
        if (w.first_of_packet) begin
            sub      = SUB_W'(w.sequence_number % PACKETS_PER_SPECTRUM);
            word_pos = 0;
            if (awaiting_start && sub != '0) begin
                pkt_dropped = 1'b1;
            end else begin
                awaiting_start = 1'b0;
                pkt_dropped    = 1'b0;
                if (have_packet && w.sequence_number != prev_seq + 64'd1)
                    r.missed_packet = 1'b1;
                have_packet = 1'b1;
                prev_seq    = w.sequence_number;
                cur_sub     = sub;
                cur_spec    = SPEC_W'(w.sequence_number / PACKETS_PER_SPECTRUM);
            end
        end else begin
            word_pos = (word_pos + 1) % WORDS;
        end

        // stored word: address, end of spectrum and missing spectra count
        if (!awaiting_start && !pkt_dropped) begin
            r.write_valid     = 1'b1;
            lin               = int'(cur_sub) * WORDS + word_pos;
            r.channel_address = ADDR_OUT_W'(band_flipped ? CHANNELS - 1 - lin : lin);
            if (cur_sub == SUB_W'(PACKETS_PER_SPECTRUM - 1) && word_pos == WORDS - 1) begin
                r.spectrum_done = 1'b1;
                if (spec_written && cur_spec > last_spec) begin
                    gap = cur_spec - last_spec - 1'b1;
                    if (gap > SPEC_W'(MAX_REPEAT))
                        gap = SPEC_W'(MAX_REPEAT);
                    if (gap > SPEC_W'(REP_MAX))
                        gap = SPEC_W'(REP_MAX);
                    r.repeat_count = gap[REP_W-1:0];
                end
                spec_written = 1'b1;
                last_spec    = cur_spec;
            end
        end else begin
            r.missed_packet = 1'b0;
        end
        return r;
    endfunction

    // names of the fields that differ
    function automatic string bad_fields(input spr_out_t want, input spr_out_t got);
        string s;
        s = "";
        if (got.write_valid !== want.write_valid)         s = {s, " write_valid"};
        if (got.channel_address !== want.channel_address) s = {s, " channel_address"};
        if (got.xx_out !== want.xx_out)                   s = {s, " xx_out"};
        if (got.yy_out !== want.yy_out)                   s = {s, " yy_out"};
        if (got.missed_packet !== want.missed_packet)     s = {s, " missed_packet"};
        if (got.spectrum_done !== want.spectrum_done)     s = {s, " spectrum_done"};
        if (got.repeat_count !== want.repeat_count)       s = {s, " repeat_count"};
        return s;
    endfunction

    function automatic string show(input spr_out_t r);
        return $sformatf("wv=%0d addr=%0d xx=%0d yy=%0d miss=%0d done=%0d rep=%0d",
                         r.write_valid, r.channel_address, r.xx_out, r.yy_out,
                         r.missed_packet, r.spectrum_done, r.repeat_count);
    endfunction

    // monitor: results are checked before new words are queued
    always @(posedge aclk) begin
        spr_out_t want;
        string    diff;
        if (!aresetn) begin
            band_flipped   = 1'b0;
            awaiting_start = 1'b1;
            have_packet    = 1'b0;
            pkt_dropped    = 1'b0;
            spec_written   = 1'b0;
            cur_sub        = '0;
            prev_seq       = '0;
            cur_spec       = '0;
            last_spec      = '0;
            word_pos       = 0;
            writes_due.delete();
            fail_count     = 0;
            writes_checked = 0;
            spectra_done   = 0;
            gaps_flagged   = 0;
            pending       <= 0;
        end else begin
            if (cfg_we)
                band_flipped = cfg_wdata;

            // compare a buffer write transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (writes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected buffer write: %s", $realtime, show(m_data));
                end else begin
                    want = writes_due.pop_front();
                    diff = bad_fields(want, m_data);
                    writes_checked++;
                    if (want.spectrum_done)
                        spectra_done++;
                    if (want.missed_packet)
                        gaps_flagged++;
                    if (diff != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: write %0d wrong in%s", $realtime, writes_checked,
                                     diff);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(m_data));
                        end
                    end
                end
            end

            // predict a channel word transfer
            if (s_valid && s_ready)
                writes_due.push_back(reassemble_word(s_data));

            pending <= writes_due.size();
        end
    end

endmodule

FILE: tb/spectrum_packet_reassembly_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_packet_reassembly_tb - testbench for spectrum packet reassembly
// Sends packetised channel words, directed then random, in bursts with gaps
// while the buffer side stalls; the checker compares every buffer write.
// ----------------------------------------------------------------------------
module spectrum_packet_reassembly_tb;
    import spr_pkg::*;

    localparam int WORDS       = CHANNELS_DEF / PACKETS_PER_SPECTRUM;
    localparam int WORD_TARGET = 1850;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic     aclk;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_wdata = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    spr_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    spr_out_t m_data;

    int fail_count;
    int pending;
    int writes_checked;
    int spectra_done;
    int gaps_flagged;

    int                words_sent = 0;
    int                burst_left = 0;
    logic [SEQ_W-1:0]  hdr_seq = '0;
    logic [SPEC_W-1:0] done_spec;

    rx_mode_t rx_mode = RX_STEADY;
    int       rx_left = 0;
    int       beat    = 0;

    spectrum_packet_reassembly dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    spr_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .writes_checked (writes_checked),
        .spectra_done   (spectra_done),
        .gaps_flagged   (gaps_flagged)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // buffer side stalls, switching pattern after each random-length run
    always @(posedge aclk) begin
        beat <= beat + 1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STEADY:   m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_ready <= (beat % 5 != 4);
            default:     m_ready <= 1'b1;
        endcase
    end

    function automatic logic [SEQ_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // powers lean towards the extremes
    function automatic logic [POWER_W-1:0] pick_power();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(POWER_W-1){1'b0}}};
            1:       return {1'b0, {(POWER_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic spr_in_t make_word(input logic [SEQ_W-1:0] seq, input logic first,
                                          input logic [POWER_W-1:0] xx,
                                          input logic [POWER_W-1:0] yy);
        spr_in_t w;
        w.sequence_number = seq;
        w.first_of_packet = first;
        w.xx_power        = xx;
        w.yy_power        = yy;
        return w;
    endfunction

    // one channel word transfer, with a random gap at the end of each burst
    task automatic push_word(input spr_in_t w);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 4)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // header word then continuation words, some carrying junk sequence numbers
    task automatic send_packet(input logic [SEQ_W-1:0] seq, input int len);
        push_word(make_word(seq, 1'b1, pick_power(), pick_power()));
        for (int i = 1; i < len; i++)
            push_word(make_word($urandom_range(0, 1) ? seq : rand64(), 1'b0,
                                pick_power(), pick_power()));
        hdr_seq = seq;
    endtask

    // hold the sender until every buffer write has come back
    task automatic wait_idle();
        int guard;
        guard    = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_band_flip(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // mostly in-order short packets, with skips, repeats and random headers
    task automatic short_traffic(input int n);
        logic [SEQ_W-1:0] seq;
        int               stop_at;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1:    seq = hdr_seq + SEQ_W'($urandom_range(2, 9));
                2:       seq = rand64();
                3:       seq = hdr_seq;
                default: seq = hdr_seq + 64'd1;
            endcase
            send_packet(seq, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(1, 8));
        end
    endtask

    // short sub-packets 0 to 2, then a full last sub-packet, sometimes overlong
    task automatic full_spectrum(input logic [SPEC_W-1:0] spec);
        for (int k = 0; k < PACKETS_PER_SPECTRUM - 1; k++)
            send_packet({spec, SUB_W'(k)}, $urandom_range(1, 3));
        send_packet({spec, SUB_W'(PACKETS_PER_SPECTRUM - 1)}, WORDS + $urandom_range(0, 2));
        done_spec = spec;
    endtask

    // stimulus
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_band_flip(1'b0);

        // directed: stray word, dropped start, in order, skip, wrap, short last
        push_word(make_word(64'd7, 1'b0, {1'b1, {(POWER_W-1){1'b0}}},
                            {1'b0, {(POWER_W-1){1'b1}}}));
        send_packet(64'd5, 2);
        push_word(make_word(64'd8, 1'b1, {1'b0, {(POWER_W-1){1'b1}}},
                            {1'b1, {(POWER_W-1){1'b0}}}));
        push_word(make_word(64'd8, 1'b0, '0, '1));
        push_word(make_word(64'd8, 1'b0, '1, '0));
        hdr_seq = 64'd8;
        send_packet(64'd9, 2);
        send_packet(64'd11, 2);
        send_packet('1, 2);
        send_packet('0, 2);
        send_packet(64'd1, 1);
        send_packet(64'd3, 1);
        wait_idle();

        // first spectrum written, mirrored band
        set_band_flip(1'b1);
        short_traffic(60);
        full_spectrum(SPEC_W'(rand64() >> 4) | SPEC_W'(16));
        wait_idle();

        // spectrum index not above the last written one
        set_band_flip(1'b0);
        short_traffic(60);
        full_spectrum(done_spec - SPEC_W'($urandom_range(0, 3)));
        wait_idle();

        // forward jump, small or saturating
        set_band_flip(1'b1);
        short_traffic(60);
        if ($urandom_range(0, 1))
            full_spectrum(done_spec + SPEC_W'($urandom_range(1, 50)));
        else
            full_spectrum(done_spec + SPEC_W'(256) + SPEC_W'(rand64() >> 8));
        wait_idle();

        // random tail
        set_band_flip(1'b0);
        short_traffic((WORD_TARGET > words_sent + 40) ? WORD_TARGET - words_sent : 40);
        wait_idle();

        $display("covered %0d channel words over five phases with band flip toggled",
                 words_sent);
        $display("%0d buffer writes checked, %0d spectra completed, %0d sequence gaps",
                 writes_checked, spectra_done, gaps_flagged);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: spectrum_packet_reassembly.f
rtl/spr_pkg.sv
rtl/spr_step.sv
rtl/spectrum_packet_reassembly.sv
tb/spr_checker.sv
tb/spectrum_packet_reassembly_tb.sv
